/* hw/rtl/bst_pkg.sv */
package bst_pkg;

	localparam int ADDR_W = 32;
	localparam int WORD_W = 32;

	localparam logic [1:0] CMD_SET  = 2'd0;
	localparam logic [1:0] CMD_FIND = 2'd1;
	localparam logic [1:0] CMD_DEL  = 2'd2;
	localparam logic [1:0] CMD_NOP  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [WORD_W-1:0] MISS_WORD = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] address;
		logic [WORD_W-1:0] saved_opcode;
	} bst_in_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [WORD_W-1:0] opcode_out;
	} bst_out_t;

	// request travelling down the chain, with what the cells behind it found
	typedef struct packed {
		logic              valid;
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] address;
		logic              hit;
		logic [WORD_W-1:0] word;
		logic              dup;
		logic              free_found;
	} bst_tok_t;

	// broadcast write into the entry picked by a set
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] address;
		logic [WORD_W-1:0] opcode;
	} bst_wr_t;

endpackage

/* hw/rtl/breakpoint_slot_table.sv */
// breakpoint slot table
// in channel: in_valid/in_ready carry one request {cmd, address, saved_opcode};
//   cmd set stores a breakpoint, find looks one up, delete removes it
// out channel: out_valid/out_ready carry one result {status, opcode_out} per request
// the entries sit in a row of NUM_ENTRIES cells; a request walks the row one
//   cell per cycle, each cell checking its own entry and passing what it saw on
// a request passes through the cell registers, the finish register and the output
//   register; one request at a time: a new one is taken only once the last result
//   is loaded into the output register
// a set writes its chosen entry in the cycle its result is loaded
// reset clears every entry to zero (all free) and drops any request in flight
// a stalled receiver holds the result in the output register; the next request
//   is still taken and walks the row, then waits at the end until the
//   output register frees up
module breakpoint_slot_table #(
	parameter int NUM_ENTRIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bst_pkg::bst_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output bst_pkg::bst_out_t out_data
);
	import bst_pkg::*;

	localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} bst_state_t;

	bst_state_t        state_q;
	logic [WORD_W-1:0] opcode_q;
	bst_tok_t          fin_q;
	logic [IDX_W-1:0]  fin_idx_q;
	logic              out_valid_q;
	bst_out_t          out_q;

	bst_tok_t          tok [NUM_ENTRIES+1];
	logic [IDX_W-1:0]  idx [NUM_ENTRIES+1];
	bst_wr_t           wr;
	logic              in_fire;
	logic              load;
	bst_out_t          res;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// request enters the first cell on the accepting edge
	always_comb begin
		tok[0].valid      = in_fire;
		tok[0].cmd        = in_data.cmd;
		tok[0].address    = in_data.address;
		tok[0].hit        = 1'b0;
		tok[0].word       = '0;
		tok[0].dup        = 1'b0;
		tok[0].free_found = 1'b0;
		idx[0]            = '0;
	end

	for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
		bst_cell #(
			.IDX   (i),
			.IDX_W (IDX_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_i    (tok[i]),
			.idx_i    (idx[i]),
			.tok_o    (tok[i+1]),
			.idx_o    (idx[i+1]),
			.wr_i     (wr),
			.wr_idx_i (fin_idx_q)
		);
	end

	// result loads once the walk is done and the output register is free
	assign load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		res.status     = ST_OK;
		res.opcode_out = '0;
		unique case (fin_q.cmd)
			CMD_SET: begin
				// an existing non-free entry with this address: ok, nothing written
				if (!fin_q.dup && !fin_q.free_found) begin
					res.status = ST_FULL;
				end
			end
			CMD_FIND, CMD_DEL: begin
				if (fin_q.hit) begin
					res.opcode_out = fin_q.word;
				end else begin
					res.status     = ST_NOT_FOUND;
					res.opcode_out = MISS_WORD;
				end
			end
			default: begin
			end
		endcase
	end

	assign wr.en      = load && (fin_q.cmd == CMD_SET) && !fin_q.dup && fin_q.free_found;
	assign wr.address = fin_q.address;
	assign wr.opcode  = opcode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok[NUM_ENTRIES].valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			opcode_q <= in_data.saved_opcode;
		end
		if (state_q == ST_SCAN && tok[NUM_ENTRIES].valid) begin
			fin_q     <= tok[NUM_ENTRIES];
			fin_idx_q <= idx[NUM_ENTRIES];
		end
		if (load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// the end of the row only ever sees a request while a walk is under way
	a_tok_end_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok[NUM_ENTRIES].valid |-> state_q == ST_SCAN)
		else $error("request left the cell row outside a walk");

	// an accepted request always starts a walk
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_SCAN)
		else $error("accepted request did not start a walk");

	// the broadcast entry write fires only for a set that found no duplicate
	a_wr_only_set: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (fin_q.cmd == CMD_SET) && !fin_q.dup)
		else $error("entry write without a clean set");

	// a new result only appears right after the done state loaded it
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared without finishing a walk");

endmodule

/* hw/rtl/bst_cell.sv */
module bst_cell #(
	parameter int IDX   = 0,
	parameter int IDX_W = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bst_pkg::bst_tok_t  tok_i,
	input  logic [IDX_W-1:0]   idx_i,
	output bst_pkg::bst_tok_t  tok_o,
	output logic [IDX_W-1:0]   idx_o,
	input  bst_pkg::bst_wr_t   wr_i,
	input  logic [IDX_W-1:0]   wr_idx_i
);
	import bst_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [ADDR_W-1:0] addr_q;
	logic [WORD_W-1:0] op_q;
	bst_tok_t          tok_q;
	logic [IDX_W-1:0]  idx_q;
	bst_tok_t          tok_nxt;
	logic [IDX_W-1:0]  idx_nxt;
	logic              is_free;
	logic              is_match;
	logic              clr;

	assign is_free  = (addr_q == '0) && (op_q == '0);
	assign is_match = (addr_q == tok_i.address);

	always_comb begin
		tok_nxt = tok_i;
		idx_nxt = idx_i;
		clr     = 1'b0;
		if (tok_i.valid) begin
			unique case (tok_i.cmd)
				CMD_SET: begin
					// later free entries override earlier ones: highest free wins
					if (is_free) begin
						tok_nxt.free_found = 1'b1;
						idx_nxt            = MY_IDX;
					end else if (is_match) begin
						tok_nxt.dup = 1'b1;
					end
				end
				CMD_FIND: begin
					if (!tok_i.hit && is_match) begin
						tok_nxt.hit  = 1'b1;
						tok_nxt.word = op_q;
					end
				end
				CMD_DEL: begin
					if (!tok_i.hit && is_match) begin
						tok_nxt.hit  = 1'b1;
						tok_nxt.word = op_q;
						clr          = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			op_q   <= '0;
		end else if (clr) begin
			addr_q <= '0;
			op_q   <= '0;
		end else if (wr_i.en && (wr_idx_i == MY_IDX)) begin
			addr_q <= wr_i.address;
			op_q   <= wr_i.opcode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			idx_q <= '0;
		end else begin
			tok_q <= tok_nxt;
			idx_q <= idx_nxt;
		end
	end

	assign tok_o = tok_q;
	assign idx_o = idx_q;

endmodule
